@@ rtl/asymmetric_slew_rate_limiter_macros.svh @@
// ----------------------------------------------------------------------------
// asymmetric slew rate limiter assertion macros
// shared concurrent check forms, clocked on clk with active low rst_n
// ----------------------------------------------------------------------------
`ifndef ASYMMETRIC_SLEW_RATE_LIMITER_MACROS_SVH
`define ASYMMETRIC_SLEW_RATE_LIMITER_MACROS_SVH

// same-cycle implication
`define ASRL_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("asrl: implication check failed");

// next-cycle implication
`define ASRL_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("asrl: next-cycle check failed");

`endif

@@ rtl/asrl_pkg.sv @@
// ----------------------------------------------------------------------------
// asrl_pkg
// widths, register codes and control types of the slew rate limiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asrl_pkg;

  localparam int VALUE_W  = 32;
  localparam int TICK_W   = 16;
  localparam int RATE_W   = 31;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int RIDX_W   = ADDR_W - 2;

  // rate * ticks, and excess * rate
  localparam int PROD_W   = TICK_W + RATE_W;
  localparam int WIDE_W   = PROD_W + RATE_W;
  // saturated step, 2^VALUE_W needs one extra bit
  localparam int DELTA_W  = VALUE_W + 1;
  localparam int MPL_W    = (RATE_W > TICK_W) ? RATE_W : TICK_W;
  localparam int DIV_W    = MPL_W + DELTA_W;
  localparam int CNT_MAX  = (MPL_W > DELTA_W) ? MPL_W : DELTA_W;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam int CMP_W    = (WIDE_W > DIV_W) ? WIDE_W : DIV_W;
  localparam int CAPCMP_W = (PROD_W > DELTA_W) ? PROD_W : DELTA_W;

  localparam logic [DELTA_W-1:0] DELTA_CAP = {1'b1, {VALUE_W{1'b0}}};

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(65536);

  // register indexes
  localparam logic [RIDX_W-1:0] REG_INC    = RIDX_W'(0);
  localparam logic [RIDX_W-1:0] REG_DEC    = RIDX_W'(1);
  localparam logic [RIDX_W-1:0] REG_FOLLOW = RIDX_W'(2);

  // arithmetic unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic go;
    logic op;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

endpackage

`default_nettype wire

@@ rtl/asrl_if.sv @@
// ----------------------------------------------------------------------------
// asrl channel interfaces
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface asrl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [asrl_pkg::VALUE_W-1:0] target;
  logic        [asrl_pkg::TICK_W-1:0]  step_ticks;
  logic signed [asrl_pkg::VALUE_W-1:0] measured;
  logic                                measured_valid;
  logic                                preset;

  modport source (
    output valid, target, step_ticks, measured, measured_valid, preset,
    input  ready
  );

  modport sink (
    input  valid, target, step_ticks, measured, measured_valid, preset,
    output ready
  );
endinterface

interface asrl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [asrl_pkg::VALUE_W-1:0] ramp_out;
  logic signed [asrl_pkg::VALUE_W-1:0] target_echo;
  logic                                status;

  modport source (
    output valid, ramp_out, target_echo, status,
    input  ready
  );

  modport sink (
    input  valid, ramp_out, target_echo, status,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/asrl_arith.sv @@
// ----------------------------------------------------------------------------
// asrl_arith
// bit-serial shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asrl_arith (
  input  logic                            clk,
  input  logic                            rst_n,
  input  asrl_pkg::arith_cmd_t            cmd,
  input  logic [asrl_pkg::WIDE_W-1:0]     opa,
  input  logic [asrl_pkg::MPL_W-1:0]      opb,
  input  logic [asrl_pkg::CNT_W-1:0]      nbits,
  output asrl_pkg::arith_sts_t            sts,
  output logic [asrl_pkg::WIDE_W-1:0]     prod,
  output logic [asrl_pkg::DELTA_W-1:0]    quo
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic                           op_r, op_nxt;
  logic [asrl_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [asrl_pkg::WIDE_W-1:0]    mcand_r, mcand_nxt;
  logic [asrl_pkg::MPL_W-1:0]     mplier_r, mplier_nxt;
  logic [asrl_pkg::WIDE_W-1:0]    acc_r, acc_nxt;
  logic [asrl_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [asrl_pkg::DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [asrl_pkg::DELTA_W-1:0]   quo_r, quo_nxt;

  logic [asrl_pkg::DIV_W-1:0]     div_lim;
  logic                           div_ovf;
  logic                           rem_ge;

  // quotient of 2^DELTA_W or more is saturated up front
  assign div_lim = {opb, {asrl_pkg::DELTA_W{1'b0}}};
  assign div_ovf = asrl_pkg::CMP_W'(opa) >= asrl_pkg::CMP_W'(div_lim);
  assign rem_ge  = rem_r >= dvs_r;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    quo_nxt    = quo_r;
    if (cmd.go) begin
      op_nxt = cmd.op;
      if (cmd.op == asrl_pkg::OP_MUL) begin
        mcand_nxt  = opa;
        mplier_nxt = opb;
        acc_nxt    = '0;
        cnt_nxt    = nbits;
        busy_nxt   = 1'b1;
      end else if (div_ovf) begin
        quo_nxt  = asrl_pkg::DELTA_CAP;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = asrl_pkg::DIV_W'(opa);
        dvs_nxt  = asrl_pkg::DIV_W'({opb, {asrl_pkg::VALUE_W{1'b0}}});
        quo_nxt  = '0;
        cnt_nxt  = asrl_pkg::CNT_W'(asrl_pkg::DELTA_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == asrl_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (op_r == asrl_pkg::OP_MUL) begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
      end else begin
        if (rem_ge) begin
          rem_nxt = rem_r - dvs_r;
        end
        quo_nxt = {quo_r[asrl_pkg::DELTA_W-2:0], rem_ge};
        dvs_nxt = dvs_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= asrl_pkg::OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    quo_r    <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;
  assign quo      = (quo_r > asrl_pkg::DELTA_CAP) ? asrl_pkg::DELTA_CAP : quo_r;

endmodule

`default_nettype wire

@@ rtl/asymmetric_slew_rate_limiter.sv @@
// path from accept to result: S_PREP then S_FIN for a preset or rejected word, S_PLAN added with no move,
// S_MUL1 for an ordinary step, S_MUL2 and S_DIV when a reversal rises again (the divide ends at once if saturated)
// one word in flight: a new word is accepted only back in S_IDLE
// the multiplier and divider in asrl_arith work one bit per cycle
// reset: synchronous active low; state clears to zero, rates to 1.0 per tick, follow off
// ----------------------------------------------------------------------------
// asymmetric_slew_rate_limiter
// ramps a Q16.16 output towards a target with separate rise and fall rates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "asymmetric_slew_rate_limiter_macros.svh"

module asymmetric_slew_rate_limiter (
  input  logic                          clk,
  input  logic                          rst_n,
  asrl_in_if.sink                       in_ch,
  asrl_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [asrl_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [asrl_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [asrl_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_PLAN = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam int VW = asrl_pkg::VALUE_W;
  localparam int DW = asrl_pkg::DELTA_W;

  function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] x);
    mag_of = x[VW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic between(input logic signed [VW-1:0] v,
                                   input logic signed [VW-1:0] a,
                                   input logic signed [VW-1:0] b);
    between = ((a <= v) && (v <= b)) || ((b <= v) && (v <= a));
  endfunction

  function automatic logic signed [VW-1:0] move_to(input logic signed [VW-1:0] cur,
                                                   input logic signed [VW-1:0] goal,
                                                   input logic [DW-1:0] maxd);
    logic [DW-1:0] d;
    logic [DW-1:0] ad;
    d  = {goal[VW-1], goal} - {cur[VW-1], cur};
    ad = d[DW-1] ? (~d + 1'b1) : d;
    if (ad <= maxd) begin
      move_to = goal;
    end else if (d[DW-1]) begin
      move_to = cur - maxd[VW-1:0];
    end else begin
      move_to = cur + maxd[VW-1:0];
    end
  endfunction

  function automatic logic [DW-1:0] cap_of(input logic [asrl_pkg::PROD_W-1:0] p);
    if (asrl_pkg::CAPCMP_W'(p) > asrl_pkg::CAPCMP_W'(asrl_pkg::DELTA_CAP)) begin
      cap_of = asrl_pkg::DELTA_CAP;
    end else begin
      cap_of = DW'(p);
    end
  endfunction

  logic [2:0]                         state_r, state_nxt;
  logic signed [VW-1:0]               out_val_r, out_val_nxt;
  logic signed [VW-1:0]               tgt_val_r, tgt_val_nxt;
  logic signed [VW-1:0]               meas_val_r, meas_val_nxt;
  logic [asrl_pkg::RATE_W-1:0]        inc_r, inc_nxt;
  logic [asrl_pkg::RATE_W-1:0]        dec_r, dec_nxt;
  logic                               follow_r, follow_nxt;
  logic                               ov_r, ov_nxt;

  logic signed [VW-1:0]               it_tgt_r;
  logic [asrl_pkg::TICK_W-1:0]        it_dt_r;
  logic signed [VW-1:0]               it_meas_r;
  logic                               it_mv_r;
  logic                               it_preset_r;
  logic                               status_r, status_nxt;
  logic                               rev_r, rev_nxt;
  logic signed [VW-1:0]               ramp_r, ramp_nxt;
  logic signed [VW-1:0]               echo_r, echo_nxt;
  logic                               ostat_r, ostat_nxt;

  asrl_pkg::arith_cmd_t               arith_cmd;
  asrl_pkg::arith_sts_t               arith_sts;
  logic [asrl_pkg::WIDE_W-1:0]        arith_opa;
  logic [asrl_pkg::MPL_W-1:0]         arith_opb;
  logic [asrl_pkg::CNT_W-1:0]         arith_nbits;
  logic [asrl_pkg::WIDE_W-1:0]        arith_prod;
  logic [DW-1:0]                      arith_quo;

  logic                               in_acc;
  logic                               cfg_wr;
  logic [asrl_pkg::RIDX_W-1:0]        cfg_idx;
  logic signed [VW-1:0]               meas_eff;
  logic                               reversed;
  logic [asrl_pkg::RATE_W-1:0]        rate_sel;
  logic [asrl_pkg::PROD_W-1:0]        prod1;
  logic [VW-1:0]                      mag_out;
  logic                               fall_ok;
  logic                               out_free;
  logic                               arith_wait;

  asrl_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (arith_cmd),
    .opa   (arith_opa),
    .opb   (arith_opb),
    .nbits (arith_nbits),
    .sts   (arith_sts),
    .prod  (arith_prod),
    .quo   (arith_quo)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx  = cfg_paddr[asrl_pkg::ADDR_W-1:2];
  assign out_free = !ov_r || out_ch.ready;

  assign meas_eff = it_mv_r ? it_meas_r : meas_val_r;
  assign reversed = ((out_val_r > 0) && (tgt_val_r < 0)) ||
                    ((out_val_r < 0) && (tgt_val_r > 0));
  assign rate_sel = reversed ? dec_r :
                    ((mag_of(tgt_val_r) > mag_of(out_val_r)) ? inc_r : dec_r);
  assign prod1    = arith_prod[asrl_pkg::PROD_W-1:0];
  assign mag_out  = mag_of(out_val_r);
  assign fall_ok  = asrl_pkg::CAPCMP_W'(prod1) <= asrl_pkg::CAPCMP_W'(mag_out);

  assign arith_wait = (state_r == S_MUL1) || (state_r == S_MUL2) || (state_r == S_DIV);

  // configuration port
  always_comb begin
    inc_nxt    = inc_r;
    dec_nxt    = dec_r;
    follow_nxt = follow_r;
    if (cfg_wr) begin
      case (cfg_idx)
        asrl_pkg::REG_INC:    inc_nxt    = cfg_pwdata[asrl_pkg::RATE_W-1:0];
        asrl_pkg::REG_DEC:    dec_nxt    = cfg_pwdata[asrl_pkg::RATE_W-1:0];
        asrl_pkg::REG_FOLLOW: follow_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      asrl_pkg::REG_INC:    cfg_prdata = asrl_pkg::DATA_W'(inc_r);
      asrl_pkg::REG_DEC:    cfg_prdata = asrl_pkg::DATA_W'(dec_r);
      asrl_pkg::REG_FOLLOW: cfg_prdata = asrl_pkg::DATA_W'(follow_r);
      default:              cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // step sequencer
  always_comb begin
    state_nxt    = state_r;
    out_val_nxt  = out_val_r;
    tgt_val_nxt  = tgt_val_r;
    meas_val_nxt = meas_val_r;
    status_nxt   = status_r;
    rev_nxt      = rev_r;
    ov_nxt       = ov_r;
    ramp_nxt     = ramp_r;
    echo_nxt     = echo_r;
    ostat_nxt    = ostat_r;
    arith_cmd    = '{go: 1'b0, op: asrl_pkg::OP_MUL};
    arith_opa    = '0;
    arith_opb    = '0;
    arith_nbits  = '0;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (it_preset_r) begin
          out_val_nxt  = it_tgt_r;
          tgt_val_nxt  = it_tgt_r;
          meas_val_nxt = it_tgt_r;
          status_nxt   = 1'b0;
          state_nxt    = S_FIN;
        end else begin
          if (it_mv_r) begin
            meas_val_nxt = it_meas_r;
          end
          if (it_dt_r == '0) begin
            status_nxt = 1'b1;
            state_nxt  = S_FIN;
          end else begin
            status_nxt  = 1'b0;
            tgt_val_nxt = it_tgt_r;
            if (follow_r && between(meas_eff, out_val_r, it_tgt_r)) begin
              out_val_nxt = meas_eff;
            end
            state_nxt = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        if (out_val_r == tgt_val_r) begin
          state_nxt = S_FIN;
        end else begin
          rev_nxt     = reversed;
          arith_cmd   = '{go: 1'b1, op: asrl_pkg::OP_MUL};
          arith_opa   = asrl_pkg::WIDE_W'(rate_sel);
          arith_opb   = asrl_pkg::MPL_W'(it_dt_r);
          arith_nbits = asrl_pkg::CNT_W'(asrl_pkg::TICK_W);
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        if (arith_sts.done) begin
          if (!rev_r) begin
            out_val_nxt = move_to(out_val_r, tgt_val_r, cap_of(prod1));
            state_nxt   = S_FIN;
          end else if (fall_ok) begin
            out_val_nxt = move_to(out_val_r, '0, cap_of(prod1));
            state_nxt   = S_FIN;
          end else begin
            // time left after reaching zero, scaled by inc/dec
            arith_cmd   = '{go: 1'b1, op: asrl_pkg::OP_MUL};
            arith_opa   = asrl_pkg::WIDE_W'(prod1 - asrl_pkg::PROD_W'(mag_out));
            arith_opb   = asrl_pkg::MPL_W'(inc_r);
            arith_nbits = asrl_pkg::CNT_W'(asrl_pkg::RATE_W);
            state_nxt   = S_MUL2;
          end
        end
      end
      S_MUL2: begin
        if (arith_sts.done) begin
          arith_cmd = '{go: 1'b1, op: asrl_pkg::OP_DIV};
          arith_opa = arith_prod;
          arith_opb = asrl_pkg::MPL_W'(dec_r);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (arith_sts.done) begin
          out_val_nxt = move_to('0, tgt_val_r, arith_quo);
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ramp_nxt  = out_val_r;
          echo_nxt  = tgt_val_r;
          ostat_nxt = status_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_val_r  <= '0;
      tgt_val_r  <= '0;
      meas_val_r <= '0;
      inc_r      <= asrl_pkg::RATE_RST;
      dec_r      <= asrl_pkg::RATE_RST;
      follow_r   <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_val_r  <= out_val_nxt;
      tgt_val_r  <= tgt_val_nxt;
      meas_val_r <= meas_val_nxt;
      inc_r      <= inc_nxt;
      dec_r      <= dec_nxt;
      follow_r   <= follow_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      it_tgt_r    <= in_ch.target;
      it_dt_r     <= in_ch.step_ticks;
      it_meas_r   <= in_ch.measured;
      it_mv_r     <= in_ch.measured_valid;
      it_preset_r <= in_ch.preset;
    end
    status_r <= status_nxt;
    rev_r    <= rev_nxt;
    ramp_r   <= ramp_nxt;
    echo_r   <= echo_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.ramp_out    = ramp_r;
  assign out_ch.target_echo = echo_r;
  assign out_ch.status      = ostat_r;

  `ASRL_ASSERT_NXT(a_accept_prep, in_acc, state_r == S_PREP)
  `ASRL_ASSERT_IMP(a_go_idle_unit, arith_cmd.go, !arith_sts.busy)
  `ASRL_ASSERT_IMP(a_done_waited, arith_sts.done, arith_wait)
  `ASRL_ASSERT_NXT(a_fin_result, (state_r == S_FIN) && out_free, out_ch.valid && (state_r == S_IDLE))

endmodule

`default_nettype wire

@@ tb/tb_asymmetric_slew_rate_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_asymmetric_slew_rate_limiter
// drives ramp words and register writes into the slew rate limiter, predicts
// every result word with a cycle-free software copy of the ramp arithmetic
// and compares each field as the result words leave the block
// ----------------------------------------------------------------------------

module tb_asymmetric_slew_rate_limiter;

  localparam int     QUIET_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     ONE          = 65536;
  localparam longint STEP_CAP     = 64'sd1 <<< asrl_pkg::VALUE_W;

  typedef struct {
    logic signed [asrl_pkg::VALUE_W-1:0] target;
    logic        [asrl_pkg::TICK_W-1:0]  ticks;
    logic signed [asrl_pkg::VALUE_W-1:0] meas;
    logic                                meas_ok;
    logic                                preset;
  } ramp_cmd_t;

  typedef struct {
    logic signed [asrl_pkg::VALUE_W-1:0] ramp;
    logic signed [asrl_pkg::VALUE_W-1:0] goal;
    logic                                rejected;
  } ramp_res_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [asrl_pkg::ADDR_W-1:0] cfg_paddr;
  logic [asrl_pkg::DATA_W-1:0] cfg_pwdata;
  logic [asrl_pkg::DATA_W-1:0] cfg_prdata;
  logic                        cfg_pready;

  asrl_in_if  in_ch ();
  asrl_out_if out_ch ();

  asymmetric_slew_rate_limiter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted block state and registers
  logic signed [asrl_pkg::VALUE_W-1:0] ramp_now;
  logic signed [asrl_pkg::VALUE_W-1:0] goal_now;
  logic signed [asrl_pkg::VALUE_W-1:0] meas_now;
  logic        [asrl_pkg::RATE_W-1:0]  rise_rate;
  logic        [asrl_pkg::RATE_W-1:0]  fall_rate;
  logic                                follow_en;

  ramp_res_t pending_ramps[$];
  int        errors    = 0;
  int        quiet     = 0;
  int        snd_idle  = 0;
  int        rcv_idle  = 0;
  int        hold_left = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint toward(longint cur, longint dest, longint maxd);
    longint d;
    d = dest - cur;
    if (mag(d) <= maxd) return dest;
    return (d > 0) ? cur + maxd : cur - maxd;
  endfunction

  function automatic ramp_res_t advance_ramp(ramp_cmd_t c);
    ramp_res_t   r;
    longint      outv;
    longint      tgt;
    longint      mv;
    longint      fall;
    longint      limit;
    logic [95:0] rise;
    r.rejected = 1'b0;
    if (c.preset) begin
      ramp_now = c.target;
      goal_now = c.target;
      meas_now = c.target;
    end else begin
      if (c.meas_ok) meas_now = c.meas;
      if (c.ticks == '0) begin
        r.rejected = 1'b1;
      end else begin
        goal_now = c.target;
        outv = ramp_now;
        tgt  = goal_now;
        mv   = meas_now;
        if (follow_en && ((outv <= mv && mv <= tgt) || (tgt <= mv && mv <= outv))) outv = mv;
        if (outv != tgt) begin
          if ((outv > 0 && tgt < 0) || (outv < 0 && tgt > 0)) begin
            // reversal: fall to zero first, leftover time rises at the scaled rate
            fall = longint'(c.ticks) * longint'(fall_rate);
            if (fall <= mag(outv)) begin
              outv = toward(outv, 0, fall);
            end else begin
              rise  = 96'(fall - mag(outv)) * 96'(rise_rate) / 96'(fall_rate);
              limit = (rise > 96'(STEP_CAP)) ? STEP_CAP : longint'(rise);
              outv  = toward(0, tgt, limit);
            end
          end else begin
            limit = longint'(c.ticks) *
                    ((mag(tgt) > mag(outv)) ? longint'(rise_rate) : longint'(fall_rate));
            if (limit > STEP_CAP) limit = STEP_CAP;
            outv = toward(outv, tgt, limit);
          end
        end
        ramp_now = outv[asrl_pkg::VALUE_W-1:0];
      end
    end
    r.ramp = ramp_now;
    r.goal = goal_now;
    return r;
  endfunction

  function automatic ramp_cmd_t mk(input logic signed [asrl_pkg::VALUE_W-1:0] tgt,
                                   input int ticks,
                                   input logic signed [asrl_pkg::VALUE_W-1:0] meas,
                                   input logic mv, input logic pre);
    ramp_cmd_t c;
    c.target  = tgt;
    c.ticks   = asrl_pkg::TICK_W'(ticks);
    c.meas    = meas;
    c.meas_ok = mv;
    c.preset  = pre;
    return c;
  endfunction

  function automatic logic [asrl_pkg::DATA_W-1:0] pick_rate();
    logic [asrl_pkg::RATE_W-1:0] r;
    case ($urandom_range(0, 4))
      0: r = asrl_pkg::RATE_W'(ONE);
      1: r = '1;
      2: r = asrl_pkg::RATE_W'(1);
      3: r = asrl_pkg::RATE_W'($urandom) >> $urandom_range(0, 30);
      default: r = asrl_pkg::RATE_W'($urandom);
    endcase
    if (r == '0) r = asrl_pkg::RATE_W'(1);
    return {1'($urandom), r};
  endfunction

  function automatic ramp_cmd_t pick_random_cmd();
    ramp_cmd_t   c;
    int          kind;
    longint      lo;
    longint      hi;
    logic [63:0] pick;
    kind      = $urandom_range(0, 99);
    c.target  = $urandom;
    c.meas    = $urandom;
    c.meas_ok = 1'($urandom);
    c.preset  = 1'b0;
    case ($urandom_range(0, 3))
      0: c.ticks = asrl_pkg::TICK_W'($urandom_range(1, 8));
      1: c.ticks = asrl_pkg::TICK_W'($urandom);
      2: c.ticks = '1;
      default: c.ticks = asrl_pkg::TICK_W'($urandom_range(1, 200));
    endcase
    if (kind < 5) begin
      c.preset = 1'b1;
      if ($urandom_range(0, 1)) c.target = $urandom_range(0, 16 * ONE) - 8 * ONE;
    end else if (kind < 12) begin
      c.ticks = '0;
    end else begin
      case ($urandom_range(0, 3))
        0: c.target = $urandom_range(0, 16 * ONE) - 8 * ONE;
        1: c.target = -ramp_now + ($urandom_range(0, 2 * ONE) - ONE);
        2: c.target = ramp_now + ($urandom_range(0, 4 * ONE) - 2 * ONE);
        default: c.target = $urandom;
      endcase
      // measured value somewhere between output and target, bounds included
      if ($urandom_range(0, 1)) begin
        lo = (c.target < ramp_now) ? c.target : ramp_now;
        hi = (c.target < ramp_now) ? ramp_now : c.target;
        pick = {$urandom, $urandom};
        c.meas = asrl_pkg::VALUE_W'(lo + longint'(pick % 64'(hi - lo + 1)));
        c.meas_ok = 1'b1;
      end
    end
    return c;
  endfunction

  // called and returns just after a falling edge
  task automatic send_cmd(input ramp_cmd_t c);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.target         = c.target;
    in_ch.step_ticks     = c.ticks;
    in_ch.measured       = c.meas;
    in_ch.measured_valid = c.meas_ok;
    in_ch.preset         = c.preset;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_ramps.push_back(advance_ramp(c));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_ramps.size() != 0) @(negedge clk);
  endtask

  // write a register while idle, then read it back
  task automatic cfg_write(input logic [asrl_pkg::RIDX_W-1:0] idx,
                           input logic [asrl_pkg::DATA_W-1:0] data);
    logic [asrl_pkg::DATA_W-1:0] back;
    logic [asrl_pkg::DATA_W-1:0] want;
    drain();
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    want = '0;
    case (idx)
      asrl_pkg::REG_INC: begin
        rise_rate = data[asrl_pkg::RATE_W-1:0];
        want = asrl_pkg::DATA_W'(rise_rate);
      end
      asrl_pkg::REG_DEC: begin
        fall_rate = data[asrl_pkg::RATE_W-1:0];
        want = asrl_pkg::DATA_W'(fall_rate);
      end
      asrl_pkg::REG_FOLLOW: begin
        follow_en = data[0];
        want = asrl_pkg::DATA_W'(follow_en);
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    back = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (back !== want) begin
      errors++;
      $display("%0t: register %0d readback expected %h got %h", $time, idx, want, back);
    end
  endtask

  task automatic test_reject_and_preset();
    send_cmd(mk(7 * ONE, 0, 5 * ONE, 1'b1, 1'b0));
    send_cmd(mk(32'sh7FFFFFFF, 0, -ONE, 1'b1, 1'b1));
    send_cmd(mk(ONE, 0, 0, 1'b0, 1'b0));
    send_cmd(mk(32'sh80000000, 16'hFFFF, 32'sh7FFFFFFF, 1'b0, 1'b1));
  endtask

  task automatic test_ramp_extremes();
    send_cmd(mk(3 * ONE, 1, 0, 1'b0, 1'b1));
    send_cmd(mk(-2 * ONE, 3, 0, 1'b0, 1'b0));   // lands exactly on zero
    send_cmd(mk(5 * ONE, 5, 0, 1'b0, 1'b0));    // lands exactly on target
    send_cmd(mk(2 * ONE, 1, 0, 1'b0, 1'b0));
    send_cmd(mk(-4 * ONE, 1, 0, 1'b0, 1'b0));
    send_cmd(mk(-4 * ONE, 3, 0, 1'b0, 1'b0));   // lands exactly on zero, no time left
    send_cmd(mk(32'sh7FFFFFFF, 16'hFFFF, 0, 1'b0, 1'b0));
    send_cmd(mk(32'sh80000000, 16'hFFFF, 0, 1'b0, 1'b0));
    send_cmd(mk(32'sh80000000, 1, 0, 1'b0, 1'b0));
  endtask

  task automatic test_follow_measured();
    cfg_write(asrl_pkg::REG_FOLLOW, 32'd1);
    send_cmd(mk(0, 1, 0, 1'b0, 1'b1));
    send_cmd(mk(10 * ONE, 1, 6 * ONE, 1'b1, 1'b0));
    send_cmd(mk(10 * ONE, 1, 7 * ONE, 1'b1, 1'b0));
    send_cmd(mk(9 * ONE, 2, 9 * ONE, 1'b1, 1'b0));
    send_cmd(mk(-3 * ONE, 0, -ONE, 1'b1, 1'b0));  // stored on a rejected word
    send_cmd(mk(-3 * ONE, 1, 0, 1'b0, 1'b0));
    send_cmd(mk(4 * ONE, 1, 12 * ONE, 1'b1, 1'b0));
    cfg_write(asrl_pkg::REG_FOLLOW, 32'd0);
  endtask

  task automatic test_asymmetric_rates();
    cfg_write(asrl_pkg::REG_INC, 32'h7FFFFFFF);
    cfg_write(asrl_pkg::REG_DEC, 32'd1);
    send_cmd(mk(1, 1, 0, 1'b0, 1'b1));
    send_cmd(mk(32'sh80000000, 16'hFFFF, 0, 1'b0, 1'b0));  // rise saturates
    send_cmd(mk(32'sh7FFFFFFF, 16'hFFFF, 0, 1'b0, 1'b0));
    send_cmd(mk(0, 1, 0, 1'b0, 1'b1));
    send_cmd(mk(32'sh7FFFFFFF, 16'hFFFF, 0, 1'b0, 1'b0));
    cfg_write(asrl_pkg::REG_INC, 32'd1);
    cfg_write(asrl_pkg::REG_DEC, 32'hFFFFFFFF);
    send_cmd(mk(-ONE, 1, 0, 1'b0, 1'b1));
    send_cmd(mk(3 * ONE, 2, 0, 1'b0, 1'b0));
  endtask

  task automatic test_zero_rates();
    cfg_write(asrl_pkg::REG_INC, 32'd0);
    cfg_write(asrl_pkg::REG_DEC, 32'd0);
    send_cmd(mk(2 * ONE, 1, 0, 1'b0, 1'b1));
    send_cmd(mk(5 * ONE, 100, 0, 1'b0, 1'b0));
    send_cmd(mk(-ONE, 100, 0, 1'b0, 1'b0));
    send_cmd(mk(ONE, 5, 0, 1'b0, 1'b0));
    cfg_write(asrl_pkg::REG_INC, 32'(ONE));
    cfg_write(asrl_pkg::REG_DEC, 32'(ONE));
  endtask

  task automatic test_random_ramps(input int snd_pct, input int rcv_pct, input int count);
    snd_idle = snd_pct;
    rcv_idle = rcv_pct;
    repeat (2) begin
      cfg_write(asrl_pkg::REG_INC, pick_rate());
      cfg_write(asrl_pkg::REG_DEC, pick_rate());
      cfg_write(asrl_pkg::REG_FOLLOW, $urandom);
      repeat (count) send_cmd(pick_random_cmd());
    end
  endtask

  // result side held off long enough for the input to back up
  task automatic test_output_stall();
    snd_idle = 0;
    rcv_idle = 0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    repeat (8) send_cmd(pick_random_cmd());
    drain();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin : check_results
    ramp_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_ramps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, got ramp_out %0d echo %0d st %b",
                 $time, out_ch.ramp_out, out_ch.target_echo, out_ch.status);
      end else begin
        want = pending_ramps.pop_front();
        if (out_ch.ramp_out !== want.ramp) begin
          errors++;
          $display("%0t: ramp_out expected %0d got %0d", $time, want.ramp, out_ch.ramp_out);
        end
        if (out_ch.target_echo !== want.goal) begin
          errors++;
          $display("%0t: target_echo expected %0d got %0d", $time, want.goal,
                   out_ch.target_echo);
        end
        if (out_ch.status !== want.rejected) begin
          errors++;
          $display("%0t: status expected %b got %b", $time, want.rejected, out_ch.status);
        end
      end
    end
  end

  // counts cycles with no word, result or register traffic
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.target         = '0;
    in_ch.step_ticks     = '0;
    in_ch.measured       = '0;
    in_ch.measured_valid = 1'b0;
    in_ch.preset         = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    ramp_now             = '0;
    goal_now             = '0;
    meas_now             = '0;
    rise_rate            = asrl_pkg::RATE_W'(ONE);
    fall_rate            = asrl_pkg::RATE_W'(ONE);
    follow_en            = 1'b0;
    snd_idle             = 16;
    rcv_idle             = 82;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reject_and_preset();
    test_ramp_extremes();
    test_follow_measured();
    test_asymmetric_rates();
    test_zero_rates();
    test_random_ramps(16, 82, 90);
    test_random_ramps(82, 16, 90);
    test_random_ramps(0, 0, 95);
    test_output_stall();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/asrl_pkg.sv
rtl/asrl_if.sv
rtl/asrl_arith.sv
rtl/asymmetric_slew_rate_limiter.sv
tb/tb_asymmetric_slew_rate_limiter.sv
